// ===== hdl/tcgr_pkg.sv =====
`default_nettype none

package tcgr_pkg;

  localparam int GLYPH_W = 8;
  localparam int GLYPH_H = 16;
  localparam int ROW_W   = 4;
  localparam int COLOR_W = 24;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_CURSOR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_X_MIN = 3'd0,
    REG_X_MAX = 3'd1,
    REG_Y_MIN = 3'd2,
    REG_Y_MAX = 3'd3,
    REG_FORE  = 3'd4,
    REG_BACK  = 3'd5
  } cfg_reg_t;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7E;

  localparam logic [7:0] COL_OFS = 8'd1;
  localparam logic [7:0] ROW_OFS = 8'd26;

  localparam logic [7:0]  X_MAX_RESET = 8'd159;
  localparam logic [6:0]  Y_MAX_RESET = 7'd79;
  localparam logic [23:0] FORE_RESET  = 24'hFFFFFF;
  localparam logic [23:0] BACK_RESET  = 24'h000000;

endpackage

`default_nettype wire

// ===== hdl/tcgr_ifs.sv =====
`default_nettype none

interface tcgr_in_if
  import tcgr_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic [6:0] glyph_index;
  logic [3:0] glyph_row;
  logic [7:0] row_bits;
  logic [4:0] cell_x;
  logic [2:0] cell_y;

  modport source (
    output valid, cmd, char_code, glyph_index, glyph_row, row_bits, cell_x, cell_y,
    input  ready
  );
  modport sink (
    input  valid, cmd, char_code, glyph_index, glyph_row, row_bits, cell_x, cell_y,
    output ready
  );
endinterface

interface tcgr_out_if
  import tcgr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         col_start;
  logic [7:0]         col_end;
  logic [7:0]         row_start;
  logic [7:0]         row_end;
  logic [COLOR_W-1:0] pixel_even;
  logic [COLOR_W-1:0] pixel_odd;
  logic               last;

  modport source (
    output valid, kind, col_start, col_end, row_start, row_end, pixel_even, pixel_odd,
           last,
    input  ready
  );
  modport sink (
    input  valid, kind, col_start, col_end, row_start, row_end, pixel_even, pixel_odd,
           last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/tcgr_font_store.sv =====
`default_nettype none

module tcgr_font_store #(
  parameter  int DEPTH = 1520,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/text_cursor_glyph_renderer.sv =====
`default_nettype none
// A printable character is accepted while idle, passes S_WRAP_X and S_WRAP_Y for cursor
// wrapping and the first font read, then sends its 64 words at one per cycle while the sink
// does not stall, a rate set by the output register that holds one word.
// Font loads, cursor commands and carriage return finish in S_IDLE; line feed passes S_WRAP_Y
// and form feed S_CLEAR, sending one word. Reset is synchronous and active low: it restores
// the area and color registers, homes the cursor and leaves the font store unwritten.

module text_cursor_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT = 95
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  tcgr_in_if.sink          in_ch,
  tcgr_out_if.source       out_ch
);

  localparam int GW    = $clog2(GLYPH_COUNT);
  localparam int AW    = GW + ROW_W;
  localparam int DEPTH = GLYPH_COUNT * GLYPH_H;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP_X,
    S_WRAP_Y,
    S_PAIR,
    S_CLEAR
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]         x_min_r, x_max_r;
  logic [6:0]         y_min_r, y_max_r;
  logic [COLOR_W-1:0] fore_r, back_r;

  logic [8:0]    cursor_x_r, cursor_x_nxt;
  logic [8:0]    cursor_y_r, cursor_y_nxt;
  logic          print_r, print_nxt;
  logic [GW-1:0] glyph_r, glyph_nxt;
  logic [7:0]    cs_r, cs_nxt;
  logic [7:0]    rs_r, rs_nxt;
  logic [1:0]    pair_r, pair_nxt;
  logic [3:0]    row_r, row_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [7:0]         out_cs_r, out_cs_nxt;
  logic [7:0]         out_ce_r, out_ce_nxt;
  logic [7:0]         out_rs_r, out_rs_nxt;
  logic [7:0]         out_re_r, out_re_nxt;
  logic [COLOR_W-1:0] out_pe_r, out_pe_nxt;
  logic [COLOR_W-1:0] out_po_r, out_po_nxt;
  logic               out_last_r, out_last_nxt;

  logic          in_acc;
  logic          can_load;
  logic          rd_en;
  logic [3:0]    rd_row;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [8:0]    y_wrapped;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign can_load = !out_valid_r || out_ch.ready;
  assign wr_en    = in_acc && (in_ch.cmd == CMD_LOAD) &&
                    ({1'b0, in_ch.glyph_index} < 8'(GLYPH_COUNT));

  assign y_wrapped = ({1'b0, cursor_y_r} + 10'd16 > {3'b000, y_max_r} + 10'd1)
                   ? {2'b00, y_min_r} : cursor_y_r;

  always_comb begin
    state_nxt     = state_r;
    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    print_nxt     = print_r;
    glyph_nxt     = glyph_r;
    cs_nxt        = cs_r;
    rs_nxt        = rs_r;
    pair_nxt      = pair_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_cs_nxt    = out_cs_r;
    out_ce_nxt    = out_ce_r;
    out_rs_nxt    = out_rs_r;
    out_re_nxt    = out_re_r;
    out_pe_nxt    = out_pe_r;
    out_po_nxt    = out_po_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_row        = row_r + 4'd1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.cmd)
            CMD_PUT: begin
              if (in_ch.char_code >= CH_FIRST && in_ch.char_code <= CH_LAST) begin
                glyph_nxt = GW'(in_ch.char_code - CH_FIRST);
                print_nxt = 1'b1;
                state_nxt = S_WRAP_X;
              end else if (in_ch.char_code == CH_LF) begin
                cursor_x_nxt = {1'b0, x_min_r};
                cursor_y_nxt = cursor_y_r + 9'd16;
                print_nxt    = 1'b0;
                state_nxt    = S_WRAP_Y;
              end else if (in_ch.char_code == CH_CR) begin
                cursor_x_nxt = {1'b0, x_min_r};
              end else if (in_ch.char_code == CH_FF) begin
                cursor_x_nxt = {1'b0, x_min_r};
                cursor_y_nxt = {2'b00, y_min_r};
                state_nxt    = S_CLEAR;
              end
            end
            CMD_CURSOR: begin
              cursor_x_nxt = {1'b0, x_min_r} + {1'b0, in_ch.cell_x, 3'b000};
              cursor_y_nxt = {2'b00, y_min_r} + {2'b00, in_ch.cell_y, 4'b0000};
            end
            default: begin
            end
          endcase
        end
      end

      S_WRAP_X: begin
        if ({1'b0, cursor_x_r} + 10'd8 > {2'b00, x_max_r} + 10'd1) begin
          cursor_x_nxt = {1'b0, x_min_r};
          cursor_y_nxt = cursor_y_r + 9'd16;
        end
        state_nxt = S_WRAP_Y;
      end

      S_WRAP_Y: begin
        cursor_y_nxt = y_wrapped;
        if (print_r) begin
          cs_nxt       = cursor_x_r[7:0] + COL_OFS;
          rs_nxt       = y_wrapped[7:0] + ROW_OFS;
          cursor_x_nxt = cursor_x_r + 9'd8;
          pair_nxt     = 2'd0;
          row_nxt      = 4'd0;
          rd_en        = 1'b1;
          rd_row       = 4'd0;
          state_nxt    = S_PAIR;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_PAIR: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_cs_nxt    = cs_r;
          out_ce_nxt    = cs_r + 8'd7;
          out_rs_nxt    = rs_r;
          out_re_nxt    = rs_r + 8'd15;
          out_pe_nxt    = rd_data[{pair_r, 1'b0}] ? fore_r : back_r;
          out_po_nxt    = rd_data[{pair_r, 1'b1}] ? fore_r : back_r;
          out_last_nxt  = (pair_r == 2'd3) && (row_r == 4'd15);
          pair_nxt      = pair_r + 2'd1;
          if (pair_r == 2'd3) begin
            row_nxt = row_r + 4'd1;
            if (row_r == 4'd15) begin
              state_nxt = S_IDLE;
            end else begin
              rd_en = 1'b1;
            end
          end
        end
      end

      S_CLEAR: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_cs_nxt    = x_min_r + COL_OFS;
          out_ce_nxt    = x_max_r + COL_OFS;
          out_rs_nxt    = {1'b0, y_min_r} + ROW_OFS;
          out_re_nxt    = {1'b0, y_max_r} + ROW_OFS;
          out_pe_nxt    = back_r;
          out_po_nxt    = back_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_x_r  <= 9'd0;
      cursor_y_r  <= 9'd0;
      print_r     <= 1'b0;
      pair_r      <= 2'd0;
      row_r       <= 4'd0;
      out_valid_r <= 1'b0;
      x_min_r     <= 8'd0;
      x_max_r     <= X_MAX_RESET;
      y_min_r     <= 7'd0;
      y_max_r     <= Y_MAX_RESET;
      fore_r      <= FORE_RESET;
      back_r      <= BACK_RESET;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      print_r     <= print_nxt;
      pair_r      <= pair_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_X_MIN: x_min_r <= cfg_data[7:0];
          REG_X_MAX: x_max_r <= cfg_data[7:0];
          REG_Y_MIN: y_min_r <= cfg_data[6:0];
          REG_Y_MAX: y_max_r <= cfg_data[6:0];
          REG_FORE:  fore_r  <= cfg_data;
          REG_BACK:  back_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    glyph_r    <= glyph_nxt;
    cs_r       <= cs_nxt;
    rs_r       <= rs_nxt;
    out_kind_r <= out_kind_nxt;
    out_cs_r   <= out_cs_nxt;
    out_ce_r   <= out_ce_nxt;
    out_rs_r   <= out_rs_nxt;
    out_re_r   <= out_re_nxt;
    out_pe_r   <= out_pe_nxt;
    out_po_r   <= out_po_nxt;
    out_last_r <= out_last_nxt;
  end

  tcgr_font_store #(
    .DEPTH (DEPTH)
  ) u_font_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({in_ch.glyph_index[GW-1:0], in_ch.glyph_row}),
    .wr_data (in_ch.row_bits),
    .rd_en   (rd_en),
    .rd_addr ({glyph_r, rd_row}),
    .rd_data (rd_data)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.col_start  = out_cs_r;
  assign out_ch.col_end    = out_ce_r;
  assign out_ch.row_start  = out_rs_r;
  assign out_ch.row_end    = out_re_r;
  assign out_ch.pixel_even = out_pe_r;
  assign out_ch.pixel_odd  = out_po_r;
  assign out_ch.last       = out_last_r;

  a_read_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (state_r == S_WRAP_Y || state_r == S_PAIR))
    else $error("font read outside the glyph sequence");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_IDLE))
    else $error("font write while a character is in progress");

  a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAIR && $past(state_r) != S_PAIR) |-> (pair_r == 2'd0 && row_r == 4'd0))
    else $error("glyph sequence did not start at the first pair");

  a_pair_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAIR && can_load) |=> out_valid_r)
    else $error("pixel pair was not presented");

  a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r) |-> out_last_r)
    else $error("clear request without last flag");

endmodule

`default_nettype wire
